FILE: rtl/srlm_pkg.sv
`timescale 1ns / 1ps
// srlm_pkg: sizes, character codes, opcode type and the star-closure function
// used by the line matcher; no dependencies

package srlm_pkg;

  localparam int PATTERN_MAX  = 128;
  localparam int POS_N        = PATTERN_MAX + 1;
  localparam int LEN_W        = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W        = $clog2(PATTERN_MAX);
  localparam int CLOSE_LEVELS = $clog2(PATTERN_MAX + 2) - 1;

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  typedef enum logic [1:0] {
    OP_TEXT   = 2'd0,
    OP_EOL    = 2'd1,
    OP_APPEND = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef logic [POS_N-1:0]       pos_t;
  typedef logic [PATTERN_MAX-1:0] pat_vec_t;

  // zero-repeat moves p -> p+2 over star positions, as a parallel prefix
  function automatic pos_t close_set(pos_t a, pat_vec_t st);
    pos_t g;
    pos_t t;
    pos_t g_n;
    pos_t t_n;
    int   d;
    g = a;
    for (int q = 0; q < POS_N; q++) begin
      t[q] = (q >= 2) ? st[q-2] : 1'b0;
    end
    for (int lv = 0; lv < CLOSE_LEVELS; lv++) begin
      d = 2 << lv;
      for (int q = 0; q < POS_N; q++) begin
        if (q >= d) begin
          g_n[q] = g[q] | (t[q] & g[q-d]);
          t_n[q] = t[q] & t[q-d];
        end else begin
          g_n[q] = g[q];
          t_n[q] = 1'b0;
        end
      end
      g = g_n;
      t = t_n;
    end
    return g;
  endfunction

endpackage

FILE: rtl/simple_regex_line_matcher.sv
`timescale 1ns / 1ps
// simple_regex_line_matcher: top level, pattern store and bit-parallel line search
// depends on srlm_pkg

// Takes one beat per clock while the input is not held back. A beat is a text
// character, an end of line, a pattern byte to append or a pattern clear (tuser
// selects which). The pattern follows the Kernighan-Pike rules (leading ^,
// trailing $, '.', x*) and holds up to 128 bytes; further bytes are dropped. Each
// end of line yields one output beat with tdata[0] set when the pattern matched
// somewhere in the line. Each beat passes through the input register, which
// feeds the active-position set and the result register. Input is held back
// only while an end of line sits in the input register and the previous result
// has not been taken. Appending or clearing the pattern abandons a line in
// progress.

module simple_regex_line_matcher (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // char_value[7:0]
  input  logic [1:0] s_axis_tuser,   // opcode[1:0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // matched[0], zero[7:1]
);

  logic                  in_valid;
  srlm_pkg::opcode_t     in_op;
  logic [7:0]            in_char;

  logic [7:0]            pat [srlm_pkg::PATTERN_MAX];
  srlm_pkg::pat_vec_t    live;
  logic [srlm_pkg::LEN_W-1:0] pat_len;
  logic                  anchored;
  logic                  dollar_last;

  srlm_pkg::pos_t        active;
  logic                  at_start;
  logic                  match_seen;

  logic                  out_valid;
  logic                  out_matched;

  logic                  s_fire;
  logic                  fire;
  logic                  can_write;
  logic [srlm_pkg::IDX_W-1:0] wr_idx;

  srlm_pkg::pat_vec_t    fit;
  srlm_pkg::pat_vec_t    stg;
  srlm_pkg::pat_vec_t    anchor_pos;
  srlm_pkg::pat_vec_t    single;
  srlm_pkg::pat_vec_t    stay_v;
  srlm_pkg::pat_vec_t    move_v;
  srlm_pkg::pos_t        end_pos;
  srlm_pkg::pos_t        start_vec;
  srlm_pkg::pos_t        zero_vec;
  srlm_pkg::pos_t        c_start;
  srlm_pkg::pos_t        c_zero;
  srlm_pkg::pos_t        seeded;
  srlm_pkg::pos_t        adv;
  srlm_pkg::pos_t        closed;
  logic                  is_anchored;
  logic                  hit_seed;
  logic                  hit_adv;
  logic                  anchor_hit;

  // handshake
  assign fire          = in_valid && ((in_op != srlm_pkg::OP_EOL) || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_matched};

  assign can_write = pat_len < srlm_pkg::LEN_W'(srlm_pkg::PATTERN_MAX);
  assign wr_idx    = pat_len[srlm_pkg::IDX_W-1:0];

  // per-position decode
  always_comb begin
    for (int p = 0; p < srlm_pkg::PATTERN_MAX; p++) begin
      fit[p] = (pat[p] == srlm_pkg::CH_DOT) || (pat[p] == in_char);
      if (p + 1 < srlm_pkg::PATTERN_MAX) begin
        stg[p]        = live[p+1] && (pat[p+1] == srlm_pkg::CH_STAR);
        anchor_pos[p] = live[p] && !live[p+1] && dollar_last;
      end else begin
        stg[p]        = 1'b0;
        anchor_pos[p] = live[p] && dollar_last;
      end
      single[p] = live[p] && !stg[p] && !anchor_pos[p];
    end
    end_pos[0] = !live[0];
    for (int q = 1; q < srlm_pkg::POS_N; q++) begin
      if (q < srlm_pkg::PATTERN_MAX) begin
        end_pos[q] = live[q-1] && !live[q];
      end else begin
        end_pos[q] = live[q-1];
      end
    end
  end

  // seeding, one character step, closure
  always_comb begin
    is_anchored = live[0] && anchored;
    zero_vec    = srlm_pkg::POS_N'(1);
    start_vec   = is_anchored ? srlm_pkg::POS_N'(2) : srlm_pkg::POS_N'(1);
    c_start     = srlm_pkg::close_set(start_vec, stg);
    c_zero      = srlm_pkg::close_set(zero_vec, stg);
    if (at_start) begin
      seeded = c_start;
    end else if (!is_anchored) begin
      seeded = active | c_zero;
    end else begin
      seeded = active;
    end
    stay_v     = seeded[srlm_pkg::PATTERN_MAX-1:0] & fit & stg;
    move_v     = seeded[srlm_pkg::PATTERN_MAX-1:0] & fit & single;
    adv        = {1'b0, stay_v} | {move_v, 1'b0};
    closed     = srlm_pkg::close_set(adv, stg);
    hit_seed   = |(seeded & end_pos);
    hit_adv    = |(closed & end_pos);
    anchor_hit = |(seeded[srlm_pkg::PATTERN_MAX-1:0] & anchor_pos);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_op   <= srlm_pkg::opcode_t'(s_axis_tuser);
      in_char <= s_axis_tdata;
    end
  end

  // pattern store
  always_ff @(posedge clk) begin
    if (fire && (in_op == srlm_pkg::OP_APPEND) && can_write) begin
      pat[wr_idx]  <= in_char;
      dollar_last  <= (in_char == srlm_pkg::CH_DOLLAR);
      if (wr_idx == '0) begin
        anchored <= (in_char == srlm_pkg::CH_CARET);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      pat_len <= '0;
    end else if (fire) begin
      if (in_op == srlm_pkg::OP_CLEAR) begin
        live    <= '0;
        pat_len <= '0;
      end else if ((in_op == srlm_pkg::OP_APPEND) && can_write) begin
        live[wr_idx] <= 1'b1;
        pat_len      <= pat_len + srlm_pkg::LEN_W'(1);
      end
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      at_start   <= 1'b1;
      match_seen <= 1'b0;
    end else if (fire) begin
      if (in_op == srlm_pkg::OP_TEXT) begin
        active     <= closed;
        at_start   <= 1'b0;
        match_seen <= match_seen || hit_seed || hit_adv;
      end else begin
        active     <= '0;
        at_start   <= 1'b1;
        match_seen <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && (in_op == srlm_pkg::OP_EOL)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (in_op == srlm_pkg::OP_EOL)) begin
      out_matched <= match_seen || hit_seed || anchor_hit;
    end
  end

endmodule

FILE: rtl/srlm_checker.sv
`timescale 1ns / 1ps
// srlm_checker: port-level assertions for the line matcher, bound to the top level
// depends on simple_regex_line_matcher

module srlm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // no result beat right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat after reset");

  // ready after reset
  a_rst_rdy: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready after reset");

  // with the result register empty the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no pending result");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

endmodule

bind simple_regex_line_matcher srlm_checker u_srlm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
